/* design/iatp_pkg.sv */
// shared types, constants and helpers for the ip address text parser
// no dependencies; imported by every module of the block
`timescale 1ns / 1ps

package iatp_pkg;

   // default depth of the parsed-text queue between front and emitter
   localparam int unsigned IATP_JOB_DEPTH = 2;

   // group index of the last result for each kind of valid address
   localparam logic [2:0] V4_LAST_INDEX = 3'd1;
   localparam logic [2:0] V6_LAST_INDEX = 3'd7;

   // separator and hex digit characters
   localparam logic [7:0] CH_COLON = 8'h3A;
   localparam logic [7:0] CH_DOT   = 8'h2E;
   localparam logic [7:0] CH_ZERO  = 8'h30;
   localparam logic [7:0] CH_NINE  = 8'h39;
   localparam logic [7:0] CH_LOW_A = 8'h61;
   localparam logic [7:0] CH_LOW_F = 8'h66;
   localparam logic [7:0] CH_UP_A  = 8'h41;
   localparam logic [7:0] CH_UP_F  = 8'h46;

   // where the ipv6 scanner stands relative to separators
   typedef enum logic [1:0] {
      PH_START,
      PH_GROUP,
      PH_COLON,
      PH_DOUBLE
   } phase_type;

   // one finished text, handed from the front to the emitter
   typedef struct packed {
      logic             ok;
      logic             ipv6;
      logic             compressed;
      logic [3:0]       head_groups;
      logic [3:0]       groups_written;
      logic [7:0][15:0] groups;
   } job_type;

   // decimal digit test
   function automatic logic is_decimal(logic [7:0] c);
      return (c >= CH_ZERO) && (c <= CH_NINE);
   endfunction

   // hex digit decode: bit 4 flags a hex digit, bits 3:0 carry its value
   function automatic logic [4:0] hex_nibble(logic [7:0] c);
      logic [4:0] r;
      r = 5'd0;
      if (is_decimal(c)) begin
         r = {1'b1, c[3:0]};
      end else if (((c >= CH_LOW_A) && (c <= CH_LOW_F)) ||
                   ((c >= CH_UP_A) && (c <= CH_UP_F))) begin
         r = {1'b1, c[3:0] + 4'd9};
      end
      return r;
   endfunction

endpackage

/* design/iatp_req_if.sv */
// character channel of the ip address text parser
// no dependencies
`timescale 1ns / 1ps

interface iatp_req_if;
   logic       valid;
   logic       ready;
   logic [7:0] character;
   logic       has_character;
   logic       end_of_text;

   modport source (output valid, output character, output has_character,
                   output end_of_text, input ready);
   modport sink (input valid, input character, input has_character,
                 input end_of_text, output ready);
endinterface

/* design/iatp_rsp_if.sv */
// result channel of the ip address text parser
// no dependencies
`timescale 1ns / 1ps

interface iatp_rsp_if;
   logic        valid;
   logic        ready;
   logic        address_valid;
   logic [15:0] group_value;
   logic [2:0]  group_index;
   logic        last_of_run;

   modport source (output valid, output address_valid, output group_value,
                   output group_index, output last_of_run, input ready);
   modport sink (input valid, input address_valid, input group_value,
                 input group_index, input last_of_run, output ready);
endinterface

/* design/iatp_front.sv */
// front end: takes one character per cycle while the job queue has room, tracks the
// parse state and builds a finished-text job on the end item; uses iatp_pkg, iatp_req_if
`timescale 1ns / 1ps

module iatp_front
   import iatp_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   iatp_req_if.sink req,
   input  logic     csr_write_enable,
   input  logic     csr_write_data,
   input  logic     job_full,
   output logic     push,
   output job_type  push_job
);

   // address family register
   logic family_ff;

   // parse state
   logic [3:0]  groups_written_ff, groups_written_in;
   logic [3:0]  head_groups_ff, head_groups_in;
   logic        compression_seen_ff, compression_seen_in;
   phase_type   phase_ff, phase_in;
   logic [15:0] hex_accum_ff, hex_accum_in;
   logic [2:0]  hex_count_ff, hex_count_in;
   logic [9:0]  dec_accum_ff, dec_accum_in;
   logic [2:0]  dec_count_ff, dec_count_in;
   logic        lead_zero_ff, lead_zero_in;
   logic        all_decimal_ff, all_decimal_in;
   logic [2:0]  octets_done_ff, octets_done_in;
   logic        in_dotted_ff, in_dotted_in;
   logic        failed_ff, failed_in;

   // stores, no reset: only entries written in the current text are read
   logic [15:0] group_store_ff [8];
   logic [7:0]  octet_store_ff [4];

   logic        grp_we;
   logic [2:0]  grp_waddr;
   logic [15:0] grp_wdata;
   logic        oct_we;
   logic [1:0]  oct_waddr;
   logic [7:0]  oct_wdata;

   logic        accept;
   logic        step;
   logic        end_accept;
   logic [7:0]  c;
   logic        is_dig;
   logic [4:0]  nib_info;
   logic        is_hex;
   logic [3:0]  nib;
   logic        digit_ok;
   logic [9:0]  dec_step;

   logic [15:0]      grp_post [8];
   logic [7:0]       oct_post [4];
   logic [7:0][15:0] fin_groups;
   logic             fin_ok;
   logic [3:0]       fin_written;
   logic             dotted_final;

   // handshake
   assign req.ready  = !job_full;
   assign accept     = req.valid && req.ready;
   assign step       = accept && req.has_character && !failed_ff;
   assign end_accept = accept && req.end_of_text;

   // character classes
   assign c        = req.character;
   assign is_dig   = is_decimal(c);
   assign nib_info = hex_nibble(c);
   assign is_hex   = nib_info[4];
   assign nib      = nib_info[3:0];
   assign digit_ok = (dec_count_ff < 3'd3) && !((dec_count_ff != 3'd0) && lead_zero_ff);
   // accum * 10 + digit; a live octet never exceeds 999
   assign dec_step = {dec_accum_ff[6:0], 3'b000} + {dec_accum_ff[8:0], 1'b0} + {6'd0, nib};

   // one character step
   always_comb begin
      groups_written_in   = groups_written_ff;
      head_groups_in      = head_groups_ff;
      compression_seen_in = compression_seen_ff;
      phase_in            = phase_ff;
      hex_accum_in        = hex_accum_ff;
      hex_count_in        = hex_count_ff;
      dec_accum_in        = dec_accum_ff;
      dec_count_in        = dec_count_ff;
      lead_zero_in        = lead_zero_ff;
      all_decimal_in      = all_decimal_ff;
      octets_done_in      = octets_done_ff;
      in_dotted_in        = in_dotted_ff;
      failed_in           = failed_ff;
      grp_we              = 1'b0;
      grp_waddr           = groups_written_ff[2:0];
      grp_wdata           = hex_accum_ff;
      oct_we              = 1'b0;
      oct_waddr           = octets_done_ff[1:0];
      oct_wdata           = dec_accum_ff[7:0];
      if (step) begin
         if (!family_ff || in_dotted_ff) begin
            // dotted decimal text
            if (is_dig) begin
               if (!digit_ok) begin
                  failed_in = 1'b1;
               end else begin
                  lead_zero_in = (dec_count_ff == 3'd0) ? (nib == 4'd0) : lead_zero_ff;
                  dec_accum_in = dec_step;
                  dec_count_in = dec_count_ff + 3'd1;
               end
            end else if (c == CH_DOT) begin
               if ((dec_count_ff == 3'd0) || (dec_accum_ff > 10'd255) ||
                   (octets_done_ff >= 3'd3)) begin
                  failed_in = 1'b1;
               end else begin
                  oct_we         = 1'b1;
                  octets_done_in = octets_done_ff + 3'd1;
                  dec_accum_in   = 10'd0;
                  dec_count_in   = 3'd0;
                  lead_zero_in   = 1'b0;
               end
            end else begin
               failed_in = 1'b1;
            end
         end else begin
            // ipv6 text
            if (is_hex) begin
               if (phase_ff == PH_GROUP) begin
                  if (hex_count_ff >= 3'd4) begin
                     failed_in = 1'b1;
                  end else begin
                     hex_accum_in = {hex_accum_ff[11:0], nib};
                     hex_count_in = hex_count_ff + 3'd1;
                     if (!is_dig || !digit_ok) begin
                        all_decimal_in = 1'b0;
                     end
                     if (is_dig && digit_ok) begin
                        lead_zero_in = (dec_count_ff == 3'd0) ? (nib == 4'd0) : lead_zero_ff;
                        dec_accum_in = dec_step;
                        dec_count_in = dec_count_ff + 3'd1;
                     end
                  end
               end else if ((phase_ff == PH_COLON) && (groups_written_ff == 4'd0)) begin
                  // text opens with a single colon
                  failed_in = 1'b1;
               end else begin
                  phase_in       = PH_GROUP;
                  hex_accum_in   = {12'd0, nib};
                  hex_count_in   = 3'd1;
                  all_decimal_in = is_dig;
                  lead_zero_in   = is_dig && (nib == 4'd0);
                  dec_accum_in   = is_dig ? {6'd0, nib} : 10'd0;
                  dec_count_in   = is_dig ? 3'd1 : 3'd0;
               end
            end else if (c == CH_COLON) begin
               unique case (phase_ff)
                  PH_START: begin
                     phase_in = PH_COLON;
                  end
                  PH_GROUP: begin
                     if (groups_written_ff >= 4'd8) begin
                        failed_in = 1'b1;
                     end else begin
                        grp_we            = 1'b1;
                        groups_written_in = groups_written_ff + 4'd1;
                     end
                     phase_in = PH_COLON;
                  end
                  PH_COLON: begin
                     if (compression_seen_ff) begin
                        failed_in = 1'b1;
                     end else begin
                        compression_seen_in = 1'b1;
                        head_groups_in      = groups_written_ff;
                        phase_in            = PH_DOUBLE;
                     end
                  end
                  PH_DOUBLE: begin
                     // empty group after the compression
                     failed_in = 1'b1;
                  end
               endcase
            end else if ((c == CH_DOT) && (phase_ff == PH_GROUP) && all_decimal_ff &&
                         (dec_count_ff != 3'd0) && (dec_accum_ff <= 10'd255)) begin
               // group turns out to be the first octet of an ipv4 tail
               oct_we         = 1'b1;
               oct_waddr      = 2'd0;
               octets_done_in = 3'd1;
               dec_accum_in   = 10'd0;
               dec_count_in   = 3'd0;
               lead_zero_in   = 1'b0;
               in_dotted_in   = 1'b1;
            end else begin
               failed_in = 1'b1;
            end
         end
      end
   end

   // stores as they stand after this character
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         grp_post[k] = (grp_we && (grp_waddr == k[2:0])) ? grp_wdata : group_store_ff[k];
      end
      for (int k = 0; k < 4; k++) begin
         oct_post[k] = (oct_we && (oct_waddr == k[1:0])) ? oct_wdata : octet_store_ff[k];
      end
   end

   assign dotted_final = (octets_done_in == 3'd3) && (dec_count_in != 3'd0) &&
                         (dec_accum_in <= 10'd255);

   // end-of-text check and final group writes
   always_comb begin
      for (int k = 0; k < 8; k++) begin
         fin_groups[k] = grp_post[k];
      end
      fin_written = groups_written_in;
      fin_ok      = !failed_in;
      if (!family_ff) begin
         fin_ok        = !failed_in && dotted_final;
         fin_groups[0] = {oct_post[0], oct_post[1]};
         fin_groups[1] = {oct_post[2], dec_accum_in[7:0]};
      end else begin
         if (in_dotted_in) begin
            fin_ok = fin_ok && dotted_final && (groups_written_in <= 4'd6);
            fin_groups[groups_written_in[2:0]]        = {oct_post[0], oct_post[1]};
            fin_groups[groups_written_in[2:0] + 3'd1] = {oct_post[2], dec_accum_in[7:0]};
            fin_written = groups_written_in + 4'd2;
         end else if (phase_in == PH_GROUP) begin
            if (groups_written_in >= 4'd8) begin
               fin_ok = 1'b0;
            end else begin
               fin_groups[groups_written_in[2:0]] = hex_accum_in;
            end
            fin_written = groups_written_in + 4'd1;
         end else if (phase_in != PH_DOUBLE) begin
            fin_ok = 1'b0;
         end
         if (compression_seen_in) begin
            fin_ok = fin_ok && (fin_written <= 4'd7) && (head_groups_in <= fin_written);
         end else begin
            fin_ok = fin_ok && (fin_written == 4'd8);
         end
      end
   end

   // job to the queue
   assign push                    = end_accept;
   assign push_job.ok             = fin_ok;
   assign push_job.ipv6           = family_ff;
   assign push_job.compressed     = family_ff && compression_seen_in;
   assign push_job.head_groups    = head_groups_in;
   assign push_job.groups_written = fin_written;
   assign push_job.groups         = fin_groups;

   // family register
   always_ff @(posedge clock) begin
      if (reset) begin
         family_ff <= 1'b1;
      end else if (csr_write_enable) begin
         family_ff <= csr_write_data;
      end
   end

   // parse state, cleared after every end item
   always_ff @(posedge clock) begin
      if (reset || end_accept) begin
         groups_written_ff   <= 4'd0;
         head_groups_ff      <= 4'd0;
         compression_seen_ff <= 1'b0;
         phase_ff            <= PH_START;
         hex_accum_ff        <= 16'd0;
         hex_count_ff        <= 3'd0;
         dec_accum_ff        <= 10'd0;
         dec_count_ff        <= 3'd0;
         lead_zero_ff        <= 1'b0;
         all_decimal_ff      <= 1'b1;
         octets_done_ff      <= 3'd0;
         in_dotted_ff        <= 1'b0;
         failed_ff           <= 1'b0;
      end else begin
         groups_written_ff   <= groups_written_in;
         head_groups_ff      <= head_groups_in;
         compression_seen_ff <= compression_seen_in;
         phase_ff            <= phase_in;
         hex_accum_ff        <= hex_accum_in;
         hex_count_ff        <= hex_count_in;
         dec_accum_ff        <= dec_accum_in;
         dec_count_ff        <= dec_count_in;
         lead_zero_ff        <= lead_zero_in;
         all_decimal_ff      <= all_decimal_in;
         octets_done_ff      <= octets_done_in;
         in_dotted_ff        <= in_dotted_in;
         failed_ff           <= failed_in;
      end
   end

   // group and octet stores
   always_ff @(posedge clock) begin
      if (grp_we) begin
         group_store_ff[grp_waddr] <= grp_wdata;
      end
      if (oct_we) begin
         octet_store_ff[oct_waddr] <= oct_wdata;
      end
   end

endmodule

/* design/iatp_job_fifo.sv */
// small queue of finished-text jobs between the front and the emitter
// uses iatp_pkg for the job type
`timescale 1ns / 1ps

module iatp_job_fifo
   import iatp_pkg::*;
#(
   parameter int unsigned DEPTH = IATP_JOB_DEPTH  // 2 to 16
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  job_type push_job,
   output logic    full,
   input  logic    pop,
   output logic    head_valid,
   output job_type head_job
);

   localparam int unsigned PTR_W = $clog2(DEPTH);
   localparam int unsigned CNT_W = $clog2(DEPTH + 1);
   localparam logic [PTR_W-1:0] PTR_LAST = PTR_W'(DEPTH - 1);
   localparam logic [CNT_W-1:0] CNT_FULL = CNT_W'(DEPTH);

   job_type          entry_ff [DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [PTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [CNT_W-1:0] count_ff, count_in;
   logic             do_push;
   logic             do_pop;

   assign full       = (count_ff == CNT_FULL);
   assign head_valid = (count_ff != '0);
   assign head_job   = entry_ff[rd_ptr_ff];
   assign do_push    = push && !full;
   assign do_pop     = pop && head_valid;

   // pointer and fill count update
   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_push) begin
         wr_ptr_in = (wr_ptr_ff == PTR_LAST) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (do_pop) begin
         rd_ptr_in = (rd_ptr_ff == PTR_LAST) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (do_push && !do_pop) begin
         count_in = count_ff + 1'b1;
      end else if (do_pop && !do_push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   // entry storage
   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_job;
      end
   end

endmodule

/* design/iatp_emitter.sv */
// back end: walks the job at the queue head and emits one result per cycle, when not
// held by rsp.ready, through an output register; uses iatp_pkg, iatp_rsp_if
`timescale 1ns / 1ps

module iatp_emitter
   import iatp_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       job_valid,
   input  job_type    job,
   output logic       pop,
   iatp_rsp_if.source rsp
);

   logic        rsp_valid_ff, rsp_valid_in;
   logic        addr_valid_ff;
   logic [15:0] value_ff;
   logic [2:0]  index_ff;
   logic        last_ff;
   logic [2:0]  idx_ff, idx_in;

   logic        slot_free;
   logic        load;
   logic        is_last;
   logic [3:0]  tail;
   logic [3:0]  gap_start;
   logic [3:0]  pos;
   logic [3:0]  src;
   logic [15:0] sel_value;

   assign slot_free = !rsp_valid_ff || rsp.ready;
   assign load      = job_valid && slot_free;
   assign pop       = load && is_last;

   // last result of the current job
   always_comb begin
      if (!job.ok) begin
         is_last = 1'b1;
      end else if (!job.ipv6) begin
         is_last = (idx_ff == V4_LAST_INDEX);
      end else begin
         is_last = (idx_ff == V6_LAST_INDEX);
      end
   end

   // group selection with the compressed gap zero-filled
   assign tail      = job.groups_written - job.head_groups;
   assign gap_start = 4'd8 - tail;
   assign pos       = {1'b0, idx_ff};
   assign src       = job.head_groups + pos - gap_start;

   always_comb begin
      if (!job.compressed || (pos < job.head_groups)) begin
         sel_value = job.groups[idx_ff];
      end else if (pos >= gap_start) begin
         sel_value = job.groups[src[2:0]];
      end else begin
         sel_value = 16'd0;
      end
   end

   // result counter and output valid
   always_comb begin
      idx_in       = idx_ff;
      rsp_valid_in = rsp_valid_ff;
      if (load) begin
         idx_in       = is_last ? 3'd0 : idx_ff + 3'd1;
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         idx_ff       <= 3'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         idx_ff       <= idx_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // output payload register
   always_ff @(posedge clock) begin
      if (load) begin
         addr_valid_ff <= job.ok;
         value_ff      <= job.ok ? sel_value : 16'd0;
         index_ff      <= job.ok ? idx_ff : 3'd0;
         last_ff       <= is_last;
      end
   end

   assign rsp.valid         = rsp_valid_ff;
   assign rsp.address_valid = addr_valid_ff;
   assign rsp.group_value   = value_ff;
   assign rsp.group_index   = index_ff;
   assign rsp.last_of_run   = last_ff;

endmodule

/* design/ip_address_text_parser.sv */
// IP address text parser. Takes an address text one character per transfer
// and, on the end item, returns its 16-bit groups (two for dotted IPv4, eight
// for IPv6 with '::' expanded) or one invalid result. The front end takes one
// character every cycle while the queue has room; each finished text goes into
// a queue of JOB_DEPTH entries, and the emitter drains the queue at one result
// per cycle while rsp.ready allows, so a text yields 1, 2 or 8 results.
// Characters keep flowing while results of earlier texts are still going
// out; req.ready drops only when the queue is full. Depends on iatp_pkg,
// iatp_req_if, iatp_rsp_if, iatp_front, iatp_job_fifo and iatp_emitter.
`timescale 1ns / 1ps

module ip_address_text_parser
   import iatp_pkg::*;
#(
   parameter int unsigned JOB_DEPTH = IATP_JOB_DEPTH
) (
   input  logic       clock,
   input  logic       reset,
   iatp_req_if.sink   req,
   iatp_rsp_if.source rsp,
   input  logic       csr_write_enable,
   input  logic       csr_write_data
);

   logic    job_full;
   logic    job_push;
   job_type push_job;
   logic    job_pop;
   logic    job_valid;
   job_type head_job;

   // character parser
   iatp_front u_front (
      .clock            (clock),
      .reset            (reset),
      .req              (req),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data),
      .job_full         (job_full),
      .push             (job_push),
      .push_job         (push_job)
   );

   // finished-text queue
   iatp_job_fifo #(
      .DEPTH (JOB_DEPTH)
   ) u_job_fifo (
      .clock      (clock),
      .reset      (reset),
      .push       (job_push),
      .push_job   (push_job),
      .full       (job_full),
      .pop        (job_pop),
      .head_valid (job_valid),
      .head_job   (head_job)
   );

   // result emitter
   iatp_emitter u_emitter (
      .clock     (clock),
      .reset     (reset),
      .job_valid (job_valid),
      .job       (head_job),
      .pop       (job_pop),
      .rsp       (rsp)
   );

endmodule

/* sim/tb_ip_address_text_parser.sv */
// testbench for the ip address text parser: directed texts, then random
// well-formed, broken and noise texts, checked against an in-bench predictor
// depends on iatp_pkg, iatp_req_if, iatp_rsp_if and ip_address_text_parser
`timescale 1ns / 1ps

module tb_ip_address_text_parser;
   import iatp_pkg::*;

   localparam int SETTLE_CYCLES   = 24;
   localparam int DRAIN_CYCLES    = 50;
   localparam int LIMIT_CYCLES    = 100000;
   localparam int HOLD_CYCLES     = 400;
   localparam int ITEMS_PER_PHASE = 18;
   localparam int BURST_TEXTS     = 6;
   localparam int NUM_ROWS        = 17;

   localparam logic FAMILY_V4 = 1'b0;
   localparam logic FAMILY_V6 = 1'b1;

   typedef struct packed {
      logic        address_valid;
      logic [15:0] group_value;
      logic [2:0]  group_index;
      logic        last_of_run;
   } group_result_type;

   // how a directed row is checked
   typedef enum {CHECK_PREDICTED, CHECK_MALFORMED, CHECK_DOTTED} row_check_type;

   typedef struct {
      logic          family;
      string         text;
      bit            closes;
      bit            end_apart;
      row_check_type check;
      logic [15:0]   high_pair;
      logic [15:0]   low_pair;
   } text_row_type;

   logic clock;
   logic reset;
   logic csr_write_enable;
   logic csr_write_data;

   iatp_req_if req_ch ();
   iatp_rsp_if rsp_ch ();

   ip_address_text_parser i_dut (
      .clock            (clock),
      .reset            (reset),
      .req              (req_ch),
      .rsp              (rsp_ch),
      .csr_write_enable (csr_write_enable),
      .csr_write_data   (csr_write_data)
   );

   // predictor state
   logic [15:0] grp_store [8];
   logic [7:0]  oct_store [4];
   logic [3:0]  grp_count;
   logic [3:0]  head_count;
   logic        compressed;
   phase_type   scan_phase;
   logic [15:0] hex_acc;
   logic [2:0]  hex_digits;
   logic [9:0]  dec_acc;
   logic [2:0]  dec_digits;
   logic        lead_zero;
   logic        all_decimal;
   logic [2:0]  oct_count;
   logic        dotted_tail;
   logic        text_bad;
   logic        family;

   // expected results and bookkeeping
   group_result_type pending_groups [$];
   group_result_type predicted [$];
   group_result_type typed_results [$];
   logic [7:0]       text_buf [$];
   int req_idle_pct;
   int rsp_idle_pct;
   int hold_requests;
   int texts_sent;
   int chars_sent;
   int counted_items;
   int results_checked;
   int mismatches;
   int cycles;

   // directed texts: reset state, extremes and a range of malformation kinds
   text_row_type directed_rows [NUM_ROWS] = '{
      '{FAMILY_V6, "", 1'b1, 1'b1, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V6, "::", 1'b1, 1'b0, CHECK_PREDICTED, 16'h0, 16'h0},
      '{FAMILY_V6, "Ffff::fFfF", 1'b1, 1'b1, CHECK_PREDICTED, 16'h0, 16'h0},
      '{FAMILY_V6, "1:2:3:4:5:6:7:8:9", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V6, ":1::", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V6, "1::2::3", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V6, "12345::", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V6, "::ffff:192.168.0.1", 1'b1, 1'b1, CHECK_PREDICTED, 16'h0, 16'h0},
      '{FAMILY_V6, "::1.2.", 1'b0, 1'b0, CHECK_PREDICTED, 16'h0, 16'h0},
      '{FAMILY_V4, "3.4", 1'b1, 1'b0, CHECK_PREDICTED, 16'h0, 16'h0},
      '{FAMILY_V4, "255.255.255.255", 1'b1, 1'b0, CHECK_DOTTED, 16'hFFFF, 16'hFFFF},
      '{FAMILY_V4, "0.0.0.0", 1'b1, 1'b1, CHECK_DOTTED, 16'h0000, 16'h0000},
      '{FAMILY_V4, "01.2.3.4", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V4, "256.1.1.1", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V4, "1.x.3.4", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V4, "", 1'b1, 1'b1, CHECK_MALFORMED, 16'h0, 16'h0},
      '{FAMILY_V4, "1.2.3", 1'b1, 1'b0, CHECK_MALFORMED, 16'h0, 16'h0}
   };

   // clock
   initial begin
      clock = 1'b0;
      forever #4 clock = ~clock;
   end

   // hex digit decode: bit 4 set for a digit, bits 3:0 its value
   function automatic logic [4:0] char_nibble(logic [7:0] c);
      logic [7:0] v;
      v = 8'h00;
      if (c >= CH_ZERO && c <= CH_NINE) begin
         v = c - CH_ZERO;
         return {1'b1, v[3:0]};
      end
      if (c >= CH_LOW_A && c <= CH_LOW_F) begin
         v = c - CH_LOW_A + 8'd10;
         return {1'b1, v[3:0]};
      end
      if (c >= CH_UP_A && c <= CH_UP_F) begin
         v = c - CH_UP_A + 8'd10;
         return {1'b1, v[3:0]};
      end
      return 5'd0;
   endfunction

   // append one character to the text being built
   function automatic void put_char(logic [7:0] ch);
      text_buf.insert(text_buf.size(), ch);
   endfunction

   // append one predicted result
   function automatic void predict(logic addr_ok, logic [15:0] value, logic [2:0] index,
                                   logic last);
      group_result_type r;
      r = '{addr_ok, value, index, last};
      predicted.insert(predicted.size(), r);
   endfunction

   // append one result typed in by hand
   function automatic void expect_typed(logic addr_ok, logic [15:0] value, logic [2:0] index,
                                        logic last);
      group_result_type r;
      r = '{addr_ok, value, index, last};
      typed_results.insert(typed_results.size(), r);
   endfunction

   function automatic void clear_octet();
      dec_acc    = 10'd0;
      dec_digits = 3'd0;
      lead_zero  = 1'b0;
   endfunction

   // adds one decimal digit to the octet; 0 when the octet breaks the rules
   function automatic bit take_digit(logic [3:0] d);
      if (dec_digits >= 3) return 1'b0;
      if (dec_digits >= 1 && lead_zero) return 1'b0;
      if (dec_digits == 0) lead_zero = (d == 4'd0);
      dec_acc = dec_acc * 10'd10 + 10'(d);
      dec_digits++;
      return 1'b1;
   endfunction

   function automatic bit octet_fits();
      return dec_digits >= 1 && dec_acc <= 10'd255;
   endfunction

   function automatic void reset_text();
      grp_count   = 4'd0;
      head_count  = 4'd0;
      compressed  = 1'b0;
      scan_phase  = PH_START;
      hex_acc     = 16'd0;
      hex_digits  = 3'd0;
      clear_octet();
      all_decimal = 1'b1;
      oct_count   = 3'd0;
      dotted_tail = 1'b0;
      text_bad    = 1'b0;
   endfunction

   function automatic void store_group(logic [15:0] v);
      if (grp_count >= 8) begin
         text_bad = 1'b1;
      end else begin
         grp_store[grp_count[2:0]] = v;
         grp_count++;
      end
   endfunction

   // one character of dotted decimal text
   function automatic void scan_dotted(logic [7:0] c);
      if (c >= CH_ZERO && c <= CH_NINE) begin
         if (!take_digit(c[3:0])) text_bad = 1'b1;
      end else if (c == CH_DOT) begin
         if (!octet_fits() || oct_count >= 3) begin
            text_bad = 1'b1;
         end else begin
            oct_store[oct_count[1:0]] = dec_acc[7:0];
            oct_count++;
            clear_octet();
         end
      end else begin
         text_bad = 1'b1;
      end
   endfunction

   // one character of ipv6 text, before any dotted tail
   function automatic void scan_hex_text(logic [7:0] c);
      logic [4:0] nib;
      bit         dig;
      nib = char_nibble(c);
      dig = (c >= CH_ZERO && c <= CH_NINE);
      if (nib[4]) begin
         if (scan_phase == PH_GROUP) begin
            if (hex_digits >= 4) begin
               text_bad = 1'b1;
               return;
            end
            hex_acc = {hex_acc[11:0], nib[3:0]};
            hex_digits++;
            if (!dig) all_decimal = 1'b0;
            else if (!take_digit(nib[3:0])) all_decimal = 1'b0;
            return;
         end
         // text that opens with a lone colon
         if (scan_phase == PH_COLON && grp_count == 0) begin
            text_bad = 1'b1;
            return;
         end
         scan_phase  = PH_GROUP;
         hex_acc     = {12'd0, nib[3:0]};
         hex_digits  = 3'd1;
         clear_octet();
         all_decimal = dig;
         if (dig) void'(take_digit(nib[3:0]));
         return;
      end
      if (c == CH_COLON) begin
         case (scan_phase)
            PH_START: scan_phase = PH_COLON;
            PH_GROUP: begin
               store_group(hex_acc);
               scan_phase = PH_COLON;
            end
            PH_COLON: begin
               if (compressed) begin
                  text_bad = 1'b1;
               end else begin
                  compressed = 1'b1;
                  head_count = grp_count;
                  scan_phase = PH_DOUBLE;
               end
            end
            default: text_bad = 1'b1;
         endcase
         return;
      end
      // start of a dotted tail
      if (c == CH_DOT && scan_phase == PH_GROUP && all_decimal && octet_fits()) begin
         oct_store[0] = dec_acc[7:0];
         oct_count    = 3'd1;
         clear_octet();
         dotted_tail  = 1'b1;
         return;
      end
      text_bad = 1'b1;
   endfunction

   // end of text: fill predicted with the groups or the invalid result
   function automatic void close_text();
      bit          ok;
      int          tail_n;
      logic [15:0] v;
      predicted.delete();
      ok = !text_bad;
      if (family == FAMILY_V4) begin
         ok = ok && oct_count == 3 && octet_fits();
         if (ok) begin
            predict(1'b1, {oct_store[0], oct_store[1]}, 3'd0, 1'b0);
            predict(1'b1, {oct_store[2], dec_acc[7:0]}, V4_LAST_INDEX, 1'b1);
         end
      end else begin
         if (ok) begin
            if (dotted_tail) begin
               ok = (oct_count == 3) && octet_fits() && grp_count <= 6;
               if (ok) begin
                  store_group({oct_store[0], oct_store[1]});
                  store_group({oct_store[2], dec_acc[7:0]});
               end
            end else if (scan_phase == PH_GROUP) begin
               store_group(hex_acc);
               ok = !text_bad;
            end else if (scan_phase != PH_DOUBLE) begin
               ok = 1'b0;
            end
         end
         if (ok) begin
            if (compressed) ok = grp_count <= 7 && head_count <= grp_count;
            else ok = (grp_count == 8);
         end
         // expand the compressed gap with zero groups
         if (ok) begin
            tail_n = int'(grp_count) - int'(head_count);
            for (int i = 0; i < 8; i++) begin
               if (!compressed || i < head_count) v = grp_store[i];
               else if (i >= 8 - tail_n) v = grp_store[int'(head_count) + i - (8 - tail_n)];
               else v = 16'd0;
               predict(1'b1, v, 3'(i), i == 7);
            end
         end
      end
      if (!ok) predict(1'b0, 16'd0, 3'd0, 1'b1);
      reset_text();
   endfunction

   function automatic void parse_item(logic [7:0] c, logic has, logic eot);
      if (has && !text_bad) begin
         if (family == FAMILY_V4 || dotted_tail) scan_dotted(c);
         else scan_hex_text(c);
      end
      if (eot) close_text();
   endfunction

   // one request transfer, with random idling ahead of it
   task automatic send_item(input logic [7:0] c, input logic has, input logic eot);
      while (int'($urandom_range(99)) < req_idle_pct) begin
         req_ch.valid <= 1'b0;
         @(posedge clock);
      end
      req_ch.valid         <= 1'b1;
      req_ch.character     <= c;
      req_ch.has_character <= has;
      req_ch.end_of_text   <= eot;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      parse_item(c, has, eot);
      if (has) chars_sent++;
      if (has || eot) counted_items++;
      if (eot) begin
         texts_sent++;
         if (typed_results.size() != 0) begin
            foreach (typed_results[k])
               pending_groups.insert(pending_groups.size(), typed_results[k]);
            typed_results.delete();
         end else begin
            foreach (predicted[k]) pending_groups.insert(pending_groups.size(), predicted[k]);
         end
      end
   endtask

   // sends text_buf, with ignored items mixed in and, if closes is set, the end on
   // the last character or on an item of its own
   task automatic send_text(input bit closes, input bit apart);
      int n;
      n = text_buf.size();
      apart = apart || (n == 0);
      for (int i = 0; i < n; i++) begin
         if ($urandom_range(99) < 6) send_item(8'($urandom_range(255)), 1'b0, 1'b0);
         send_item(text_buf[i], 1'b1, closes && !apart && i == n - 1);
      end
      if (closes && apart) send_item(8'($urandom_range(255)), 1'b0, 1'b1);
   endtask

   // register write once all results are out and the block has settled
   task automatic set_family(input logic fam);
      req_ch.valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
      csr_write_enable <= 1'b1;
      csr_write_data   <= fam;
      @(posedge clock);
      csr_write_enable <= 1'b0;
      family = fam;
   endtask

   // four decimal octets joined by dots
   function automatic void append_quad();
      int v;
      for (int k = 0; k < 4; k++) begin
         if (k > 0) put_char(CH_DOT);
         case ($urandom_range(5))
            0: v = 0;
            1: v = 255;
            default: v = $urandom_range(255);
         endcase
         if (v >= 100) put_char(8'(int'(CH_ZERO) + v / 100));
         if (v >= 10) put_char(8'(int'(CH_ZERO) + (v / 10) % 10));
         put_char(8'(int'(CH_ZERO) + v % 10));
      end
   endfunction

   // one hex group, padded to a random width, random letter case
   function automatic void append_group();
      int v;
      int lo;
      int n;
      int d;
      case ($urandom_range(7))
         0: v = 0;
         1: v = 'hFFFF;
         default: v = $urandom_range('hFFFF);
      endcase
      lo = 1;
      if (v > 'hF) lo = 2;
      if (v > 'hFF) lo = 3;
      if (v > 'hFFF) lo = 4;
      n = $urandom_range(4, lo);
      for (int k = n - 1; k >= 0; k--) begin
         d = (v >> (4 * k)) & 15;
         if (d < 10) put_char(8'(int'(CH_ZERO) + d));
         else if ($urandom_range(1)) put_char(8'(int'(CH_LOW_A) + d - 10));
         else put_char(8'(int'(CH_UP_A) + d - 10));
      end
   endfunction

   // random text: mostly well-formed, some broken, some noise or empty
   function automatic void build_text(input logic fam);
      int         kind;
      int         h;
      int         t;
      int         k;
      int         pos;
      bit         packed_form;
      bit         dotted;
      logic [7:0] junk;
      text_buf.delete();
      kind = $urandom_range(99);
      if (kind < 4) return;
      if (kind < 12) begin
         repeat ($urandom_range(10, 1)) put_char(8'($urandom_range(255)));
         return;
      end
      if (fam == FAMILY_V4) begin
         append_quad();
      end else begin
         packed_form = ($urandom_range(2) != 0);
         dotted      = ($urandom_range(3) == 0);
         if (!packed_form) begin
            for (int i = 0; i < (dotted ? 6 : 8); i++) begin
               if (i > 0) put_char(CH_COLON);
               append_group();
            end
            if (dotted) begin
               put_char(CH_COLON);
               append_quad();
            end
         end else begin
            k = dotted ? 5 : 7;
            h = $urandom_range(k);
            t = $urandom_range(k - h);
            for (int i = 0; i < h; i++) begin
               if (i > 0) put_char(CH_COLON);
               append_group();
            end
            put_char(CH_COLON);
            put_char(CH_COLON);
            for (int i = 0; i < t; i++) begin
               if (i > 0) put_char(CH_COLON);
               append_group();
            end
            if (dotted) begin
               if (t > 0) put_char(CH_COLON);
               append_quad();
            end
         end
      end
      // broken text: one edit of a well-formed one
      if (kind >= 78) begin
         pos = $urandom_range(text_buf.size() - 1);
         case ($urandom_range(4))
            0: junk = CH_COLON;
            1: junk = CH_DOT;
            2: junk = CH_ZERO;
            3: junk = CH_NINE;
            default: junk = 8'($urandom_range(255));
         endcase
         case ($urandom_range(3))
            0: text_buf[pos] = junk;
            1: text_buf.delete(pos);
            2: text_buf.insert(pos, junk);
            default: while (text_buf.size() > pos) void'(text_buf.pop_back());
         endcase
      end
   endfunction

   // compare one result transfer with the oldest expectation
   function automatic void check_group(group_result_type got);
      group_result_type want;
      if (pending_groups.size() == 0) begin
         mismatches++;
         $display("%0t: unexpected result, valid %0b value %h index %0d last %0b", $time,
                  got.address_valid, got.group_value, got.group_index, got.last_of_run);
         return;
      end
      want = pending_groups.pop_front();
      results_checked++;
      if (got.address_valid !== want.address_valid) begin
         mismatches++;
         $display("%0t: address_valid expected %0b actual %0b", $time,
                  want.address_valid, got.address_valid);
      end
      if (got.group_value !== want.group_value) begin
         mismatches++;
         $display("%0t: group_value expected %h actual %h", $time,
                  want.group_value, got.group_value);
      end
      if (got.group_index !== want.group_index) begin
         mismatches++;
         $display("%0t: group_index expected %0d actual %0d", $time,
                  want.group_index, got.group_index);
      end
      if (got.last_of_run !== want.last_of_run) begin
         mismatches++;
         $display("%0t: last_of_run expected %0b actual %0b", $time,
                  want.last_of_run, got.last_of_run);
      end
   endfunction

   // result side: random stalls, long hold-off on request, checking
   initial begin
      int               hold_left;
      int               hold_seen;
      group_result_type seen;
      hold_left = 0;
      hold_seen = 0;
      rsp_ch.ready = 1'b0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_ch.valid && rsp_ch.ready) begin
            seen.address_valid = rsp_ch.address_valid;
            seen.group_value   = rsp_ch.group_value;
            seen.group_index   = rsp_ch.group_index;
            seen.last_of_run   = rsp_ch.last_of_run;
            check_group(seen);
         end
         if (hold_seen != hold_requests) begin
            hold_seen = hold_requests;
            hold_left = HOLD_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_ch.ready <= 1'b0;
         end else begin
            rsp_ch.ready <= (int'($urandom_range(99)) >= rsp_idle_pct);
         end
      end
   end

   // run limit
   initial begin
      cycles = 0;
      while (cycles < LIMIT_CYCLES) begin
         @(posedge clock);
         cycles++;
      end
      $display("%0t: run limit reached with %0d results outstanding", $time,
               pending_groups.size());
      $display("tb: failure");
      $finish;
   end

   // stimulus
   initial begin
      req_ch.valid         = 1'b0;
      req_ch.character     = 8'h00;
      req_ch.has_character = 1'b0;
      req_ch.end_of_text   = 1'b0;
      csr_write_enable     = 1'b0;
      csr_write_data       = 1'b0;
      reset                = 1'b1;
      foreach (grp_store[k]) grp_store[k] = 16'd0;
      foreach (oct_store[k]) oct_store[k] = 8'd0;
      reset_text();
      family          = FAMILY_V6;
      hold_requests   = 0;
      texts_sent      = 0;
      chars_sent      = 0;
      counted_items   = 0;
      results_checked = 0;
      mismatches      = 0;
      req_idle_pct    = 29;
      rsp_idle_pct    = 50;
      repeat (10) @(posedge clock);
      reset <= 1'b0;

      // directed texts, family changes in mid-text included
      for (int r = 0; r < NUM_ROWS; r++) begin
         if (directed_rows[r].family !== family) set_family(directed_rows[r].family);
         text_buf.delete();
         for (int i = 0; i < directed_rows[r].text.len(); i++)
            put_char(directed_rows[r].text[i]);
         case (directed_rows[r].check)
            CHECK_MALFORMED: expect_typed(1'b0, 16'd0, 3'd0, 1'b1);
            CHECK_DOTTED: begin
               expect_typed(1'b1, directed_rows[r].high_pair, 3'd0, 1'b0);
               expect_typed(1'b1, directed_rows[r].low_pair, V4_LAST_INDEX, 1'b1);
            end
            default: ;
         endcase
         send_text(directed_rows[r].closes, directed_rows[r].end_apart);
      end

      // random texts: three idle patterns, each over both families
      for (int m = 0; m < 3; m++) begin
         case (m)
            0: begin
               req_idle_pct = 29;
               rsp_idle_pct = 50;
            end
            1: begin
               req_idle_pct = 50;
               rsp_idle_pct = 29;
            end
            default: begin
               req_idle_pct = 0;
               rsp_idle_pct = 0;
            end
         endcase
         for (int f = 0; f < 2; f++) begin
            set_family(f == 0 ? FAMILY_V4 : FAMILY_V6);
            counted_items = 0;
            // long result hold-off with a burst of empty texts behind it
            if (m == 2 && f == 1) begin
               hold_requests++;
               text_buf.delete();
               repeat (BURST_TEXTS) send_text(1'b1, 1'b1);
            end
            while (counted_items < ITEMS_PER_PHASE) begin
               build_text(family);
               send_text(1'b1, 1'($urandom_range(1)));
            end
         end
      end

      // drain
      req_ch.valid <= 1'b0;
      while (pending_groups.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("tb: %0d texts, %0d characters, %0d results checked, %0d mismatches",
               texts_sent, chars_sent, results_checked, mismatches);
      $display("tb: both address families, three idle patterns and one long result stall");
      if (mismatches == 0 && pending_groups.size() == 0) begin
         $display("tb: success");
      end else begin
         $display("tb: failure");
      end
      $finish;
   end

endmodule
